// ===== rtl/imm_pkg.sv =====
// Shared constants and helpers for the integer matrix multiplier.
`default_nettype none

package imm_pkg;

    localparam int IDX_W    = 3;
    localparam int DIM_W    = 4;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W  = 40;

    localparam int DEF_MAX_DIM    = 8;
    localparam int DEF_DATA_WIDTH = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD_A   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // A dimension of zero counts as one, anything above the limit counts as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 4'd1;
        end else if (v > max_dim) begin
            r = max_dim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_matrix_multiply.sv =====
// Integer matrix multiplier with element stores and one shared multiply-accumulate.
//
// Usage: the slave stream carries one command word per transfer. s_tuser holds the
// command (load A element, load B element, multiply); s_tdata holds row, column and
// the signed 32-bit value. A load emits nothing. A multiply emits the elements of
// C = A x B in row-major order on the master stream, with m_tlast on the final word,
// or a single word with m_tuser set when a_cols and b_rows differ. The user must
// write the four dimension registers over the configuration channel only while the
// block idles; the block itself does not enforce this.
// Timing: a multiply first passes the start state; then, for each result word, the
// single multiply-accumulate takes one term per cycle, limited by the one read port
// of each element store, followed by the read, product and accumulate registers and
// the hand-off into the output register. s_tready is low until the last result word
// has entered the output register; that word may still wait there while new loads
// are accepted. A stalled receiver holds the current word in the output register
// and the sequencer waits with the finished sum until the register frees up.
// Reset (synchronous, active low) sets all dimensions to eight and empties the
// output; the element stores are undefined until written.
`default_nettype none

module integer_matrix_multiply #(
    parameter int MAX_DIM    = imm_pkg::DEF_MAX_DIM,
    parameter int DATA_WIDTH = imm_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Slave stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // elem_row[2:0], elem_col[5:3], elem_value[37:6], zero[39:38]
    input  wire logic [imm_pkg::TDATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  wire logic [imm_pkg::CMD_W-1:0]       s_tuser,
    // Master stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_row[2:0], out_col[5:3], out_value[37:6], zero[39:38]
    output logic [imm_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                 m_tlast,
    // incompatible[0]
    output logic                                 m_tuser,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [imm_pkg::DIM_W-1:0]       cfg_data
);

    // Only the low 32 bits of any sum reach the output, so arithmetic stops there.
    localparam int CalcW = (DATA_WIDTH < imm_pkg::VAL_W) ? DATA_WIDTH : imm_pkg::VAL_W;
    localparam int Depth = MAX_DIM * MAX_DIM;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam logic [5:0] MaxDim6 = 6'(MAX_DIM);
    localparam logic [imm_pkg::DIM_W-1:0] MaxDim4 = imm_pkg::DIM_W'(MAX_DIM);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [imm_pkg::DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [imm_pkg::DIM_W-1:0] nr, nk, nbr, nc;

    logic [1:0]               state_reg, state_next;
    logic [imm_pkg::IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic                     res_ready_reg, res_ready_next;

    logic                     out_valid_reg, out_valid_next;
    logic [imm_pkg::IDX_W-1:0] out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [imm_pkg::VAL_W-1:0] out_val_reg, out_val_next;
    logic                     out_last_reg, out_last_next, out_inc_reg, out_inc_next;

    logic [CalcW-1:0]         a_mem [Depth];
    logic [CalcW-1:0]         b_mem [Depth];
    logic [CalcW-1:0]         rd_a_reg, rd_b_reg, prod_reg, acc_reg;
    logic                     v1_reg, f1_reg, l1_reg, v2_reg, f2_reg, l2_reg;

    logic [imm_pkg::IDX_W-1:0] in_row, in_col;
    logic [imm_pkg::VAL_W-1:0] in_value;
    logic                     s_acc, load_ok, out_free;
    logic                     k_last, i_last, j_last;
    logic [AddrW-1:0]         w_addr, a_raddr, b_raddr;

    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[37:6];

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign nr  = imm_pkg::clamp_dim(a_rows_reg, MaxDim4);
    assign nk  = imm_pkg::clamp_dim(a_cols_reg, MaxDim4);
    assign nbr = imm_pkg::clamp_dim(b_rows_reg, MaxDim4);
    assign nc  = imm_pkg::clamp_dim(b_cols_reg, MaxDim4);

    assign k_last = ({1'b0, k_reg} == nk - 4'd1);
    assign i_last = ({1'b0, i_reg} == nr - 4'd1);
    assign j_last = ({1'b0, j_reg} == nc - 4'd1);

    assign load_ok  = ({1'b0, in_row} < MaxDim4) && ({1'b0, in_col} < MaxDim4);
    assign w_addr   = AddrW'(6'(in_row) * MaxDim6 + 6'(in_col));
    assign a_raddr  = AddrW'(6'(i_reg) * MaxDim6 + 6'(k_reg));
    assign b_raddr  = AddrW'(6'(k_reg) * MaxDim6 + 6'(j_reg));
    assign out_free = !out_valid_reg || m_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg <= imm_pkg::DIM_RESET;
            a_cols_reg <= imm_pkg::DIM_RESET;
            b_rows_reg <= imm_pkg::DIM_RESET;
            b_cols_reg <= imm_pkg::DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                imm_pkg::REG_A_ROWS: a_rows_reg <= cfg_data;
                imm_pkg::REG_A_COLS: a_cols_reg <= cfg_data;
                imm_pkg::REG_B_ROWS: b_rows_reg <= cfg_data;
                imm_pkg::REG_B_COLS: b_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Element stores: written by load words, read once per cycle while issuing terms.
    always_ff @(posedge aclk) begin
        if (s_acc && load_ok && (s_tuser == imm_pkg::CMD_LOAD_A)) begin
            a_mem[w_addr] <= CalcW'(in_value);
        end
        rd_a_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && load_ok && (s_tuser == imm_pkg::CMD_LOAD_B)) begin
            b_mem[w_addr] <= CalcW'(in_value);
        end
        rd_b_reg <= b_mem[b_raddr];
    end

    // Multiply-accumulate pipeline: read, multiply, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_ISSUE);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_reg   <= (k_reg == '0);
        l1_reg   <= k_last;
        f2_reg   <= f1_reg;
        l2_reg   <= l1_reg;
        prod_reg <= CalcW'(rd_a_reg * rd_b_reg);
        if (v2_reg) begin
            acc_reg <= f2_reg ? prod_reg : acc_reg + prod_reg;
        end
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        res_ready_next = res_ready_reg || (v2_reg && l2_reg);
        out_valid_next = out_valid_reg && !m_tready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_inc_next   = out_inc_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == imm_pkg::CMD_MULTIPLY)) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (nk != nbr) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_row_next   = '0;
                        out_col_next   = '0;
                        out_val_next   = '0;
                        out_last_next  = 1'b1;
                        out_inc_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                k_next = k_reg + 3'd1;
                if (k_last) begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (res_ready_reg && out_free) begin
                    res_ready_next = 1'b0;
                    out_valid_next = 1'b1;
                    out_row_next   = i_reg;
                    out_col_next   = j_reg;
                    out_val_next   = imm_pkg::VAL_W'(acc_reg);
                    out_last_next  = i_last && j_last;
                    out_inc_next   = 1'b0;
                    if (i_last && j_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ISSUE;
                        if (j_last) begin
                            j_next = '0;
                            i_next = i_reg + 3'd1;
                        end else begin
                            j_next = j_reg + 3'd1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            res_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            res_ready_reg <= res_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_inc_reg  <= out_inc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_val_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_inc_reg;

    // A term enters the pipeline only from the issue state.
    a_issue_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> $past(state_reg) == ST_ISSUE)
        else $error("pipeline term without issue");

    // A finished sum waits alone: no term of the next element is in flight.
    a_sum_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        res_ready_reg |-> !v1_reg && !v2_reg)
        else $error("finished sum overlaps pipeline work");

    // The incompatible word is always the last word of its run.
    a_incomp_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("incompatible word malformed");

    // An accepted multiply closes the slave side on the next cycle.
    a_mul_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == imm_pkg::CMD_MULTIPLY) |=> !s_tready)
        else $error("ready during multiply");

endmodule

`default_nettype wire

// ===== bench/tb_integer_matrix_multiply.sv =====
// Self-checking bench for the integer matrix multiplier: element loads, products, dimension changes.
module tb_integer_matrix_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    import imm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 40;
    localparam int ITEM_TARGET   = 330;
    localparam int QUIET_FROM    = 280;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             incompatible;
    } product_word_t;

    // Keeps its own copy of both element stores and the dimension registers, and the
    // product words that the block still owes.
    class product_scoreboard;
        logic [VAL_W-1:0] a_mem [DEF_MAX_DIM][DEF_MAX_DIM];
        logic [VAL_W-1:0] b_mem [DEF_MAX_DIM][DEF_MAX_DIM];
        logic [DIM_W-1:0] dims [4];
        product_word_t    due_q [$];
        int               errors;

        function new();
            foreach (dims[i]) dims[i] = DIM_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            dims[idx] = val;
        endfunction

        // Zero is taken as one, anything past the largest size as the largest size.
        function int used_dim(logic [CFG_IDX_W-1:0] idx);
            if (dims[idx] == 0) return 1;
            if (dims[idx] > DEF_MAX_DIM) return DEF_MAX_DIM;
            return int'(dims[idx]);
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        function void note_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, logic [VAL_W-1:0] value);
            int nr;
            int nk;
            int nc;
            logic [VAL_W-1:0] acc;
            product_word_t w;
            case (cmd)
                CMD_LOAD_A: a_mem[row][col] = value;
                CMD_LOAD_B: b_mem[row][col] = value;
                CMD_MULTIPLY: begin
                    nr = used_dim(REG_A_ROWS);
                    nk = used_dim(REG_A_COLS);
                    nc = used_dim(REG_B_COLS);
                    if (nk != used_dim(REG_B_ROWS)) begin
                        w = '{3'd0, 3'd0, 32'd0, 1'b1, 1'b1};
                        due_q.push_back(w);
                    end else begin
                        for (int i = 0; i < nr; i++) begin
                            for (int j = 0; j < nc; j++) begin
                                acc = '0;
                                for (int k = 0; k < nk; k++)
                                    acc = acc + a_mem[i][k] * b_mem[k][j];
                                w = '{3'(i), 3'(j), acc,
                                      (i == nr - 1 && j == nc - 1), 1'b0};
                                due_q.push_back(w);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(product_word_t got);
            product_word_t want;
            if (due_q.size() == 0) begin
                $error("Unexpected result word at row %0d, column %0d", got.row, got.col);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got.row != want.row) begin
                $error("out_row: expected %0d, actual %0d", want.row, got.row);
                errors++;
            end
            if (got.col != want.col) begin
                $error("out_col: expected %0d, actual %0d", want.col, got.col);
                errors++;
            end
            if (got.value != want.value) begin
                $error("out_value: expected %0d, actual %0d",
                       $signed(want.value), $signed(got.value));
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
            if (got.incompatible != want.incompatible) begin
                $error("incompatible: expected %0d, actual %0d",
                       want.incompatible, got.incompatible);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]      cfg_data;

    product_scoreboard books = new();
    product_word_t     seen;
    bit                a_set [DEF_MAX_DIM][DEF_MAX_DIM];
    bit                b_set [DEF_MAX_DIM][DEF_MAX_DIM];
    int                items_sent = 0;
    bit                quiet = 1'b0;

    integer_matrix_multiply uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver with short random stalls, steady once the run winds down.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = '{m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast, m_tuser};
            books.check_result(seen);
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small sizes, now and then zero, the largest, or values past the largest.
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            3: return 4'($urandom_range(9, 14));
            4: return 4'($urandom_range(4, 7));
            default: return 4'($urandom_range(1, 3));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken,
    // with s_tvalid still high so that a following word goes out without a gap.
    task automatic drive_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                              logic [IDX_W-1:0] col, logic [VAL_W-1:0] value);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, value, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        books.note_word(cmd, row, col, value);
        if (cmd == CMD_LOAD_A) a_set[row][col] = 1'b1;
        if (cmd == CMD_LOAD_B) b_set[row][col] = 1'b1;
        if (cmd != CMD_UNUSED) items_sent++;
        if (items_sent >= QUIET_FROM) quiet = 1'b1;
        @(negedge aclk);
    endtask

    // Writes all four dimensions once the block has delivered everything it owes.
    task automatic program_dims(logic [DIM_W-1:0] a_rows, logic [DIM_W-1:0] a_cols,
                                logic [DIM_W-1:0] b_rows, logic [DIM_W-1:0] b_cols);
        logic [DIM_W-1:0] vals [4];
        vals = '{a_rows, a_cols, b_rows, b_cols};
        s_tvalid <= 1'b0;
        while (books.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            books.set_reg(CFG_IDX_W'(i), vals[i]);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // A product must never read an element that was not loaded, so any gap in the
    // operand region gets a random value first.
    task automatic run_product();
        int nr;
        int nk;
        int nc;
        nr = books.used_dim(REG_A_ROWS);
        nk = books.used_dim(REG_A_COLS);
        nc = books.used_dim(REG_B_COLS);
        if (nk == books.used_dim(REG_B_ROWS)) begin
            for (int i = 0; i < nr; i++)
                for (int k = 0; k < nk; k++)
                    if (!a_set[i][k]) drive_word(CMD_LOAD_A, 3'(i), 3'(k), pick_value());
            for (int k = 0; k < nk; k++)
                for (int j = 0; j < nc; j++)
                    if (!b_set[k][j]) drive_word(CMD_LOAD_B, 3'(k), 3'(j), pick_value());
        end
        drive_word(CMD_MULTIPLY, 3'($urandom), 3'($urandom), $urandom);
    endtask

    task automatic random_loads();
        int nr;
        int nk;
        int nc;
        int pick;
        nr = books.used_dim(REG_A_ROWS);
        nk = books.used_dim(REG_A_COLS);
        nc = books.used_dim(REG_B_COLS);
        repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                drive_word(CMD_UNUSED, 3'($urandom), 3'($urandom), $urandom);
            else if (pick < 4)
                drive_word(pick[0] ? CMD_LOAD_A : CMD_LOAD_B, 3'($urandom), 3'($urandom),
                           pick_value());
            else if (pick < 12)
                drive_word(CMD_LOAD_A, 3'($urandom_range(0, nr - 1)),
                           3'($urandom_range(0, nk - 1)), pick_value());
            else
                drive_word(CMD_LOAD_B, 3'($urandom_range(0, nk - 1)),
                           3'($urandom_range(0, nc - 1)), pick_value());
        end
    endtask

    initial begin
        logic [DIM_W-1:0] d0;
        logic [DIM_W-1:0] d1;
        logic [DIM_W-1:0] d2;
        logic [DIM_W-1:0] d3;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // One by one: the most negative value times minus one wraps to itself.
        program_dims(4'd1, 4'd1, 4'd1, 4'd1);
        drive_word(CMD_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        drive_word(CMD_LOAD_B, 3'd0, 3'd0, 32'hFFFF_FFFF);
        run_product();
        // The unused command must leave both stores alone.
        drive_word(CMD_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
        run_product();
        drive_word(CMD_LOAD_A, 3'd7, 3'd7, 32'h7FFF_FFFF);
        drive_word(CMD_LOAD_B, 3'd7, 3'd7, 32'h7FFF_FFFF);
        // Fifteen rows act as eight and zero columns as one.
        program_dims(4'd15, 4'd0, 4'd1, 4'd0);
        run_product();
        program_dims(4'd2, 4'd8, 4'd3, 4'd2);
        run_product();
        // Two large positive products whose sum overflows.
        program_dims(4'd1, 4'd2, 4'd2, 4'd1);
        drive_word(CMD_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        drive_word(CMD_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
        drive_word(CMD_LOAD_B, 3'd0, 3'd0, 32'd2);
        drive_word(CMD_LOAD_B, 3'd1, 3'd0, 32'd2);
        run_product();

        while (items_sent < ITEM_TARGET) begin
            d0 = pick_dim();
            d1 = pick_dim();
            d3 = pick_dim();
            case ($urandom_range(0, 7))
                0: d2 = pick_dim();
                1: d2 = (d1 >= 4'd8 || d1 == 4'd0) ? pick_dim() : d1 + 4'd1;
                default: d2 = d1;
            endcase
            program_dims(d0, d1, d2, d3);
            repeat ($urandom_range(1, 3)) begin
                random_loads();
                run_product();
            end
        end

        s_tvalid <= 1'b0;
        while (books.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (books.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== integer_matrix_multiply.f =====
rtl/imm_pkg.sv
rtl/integer_matrix_multiply.sv
bench/tb_integer_matrix_multiply.sv
